>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the binary gcd unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/bgcd_pkg.sv
// Package of the binary gcd unit: widths, datapath operation codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package bgcd_pkg;

   // Width of the operand and result ports.
   localparam int FIELD_WIDTH = 32;

   // Default working width of the datapath.
   localparam int WIDTH_DEFAULT = 32;

   // Operations the controller asks of the datapath in one cycle.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_SHIFT_BOTH,
      OP_SHIFT_BIG,
      OP_SHIFT_SMALL,
      OP_SUBTRACT,
      OP_EMIT
   } op_type;

   // Command from controller to datapath.
   typedef struct packed {
      op_type op;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic small_zero;
      logic big_even;
      logic small_even;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/binary_gcd_unit.sv
// Top level of the binary gcd unit: controller plus datapath.
// Depends on bgcd_pkg, bgcd_ctrl, bgcd_datapath and assert_macros.svh.
//
// Usage: drive req_first_value and req_second_value and raise start while
// busy is low; the pair is taken at that rising edge and busy goes high.
// The unit returns gcd(first, second) by Stein's method, with gcd(x, 0) = x
// and gcd(0, 0) = 0. Operands are taken modulo 2^WIDTH.
// The result is on rsp_gcd_value for exactly one cycle, marked by rsp_valid;
// busy drops in that same cycle, so the next pair may be given then.
// Steps: after the load the result is emitted at once when an operand is
// zero; otherwise the datapath first strips factors of two from both
// operands, keeping count of the shared ones, then reduces the values by
// single-bit right shifts and subtractions until the smaller one is zero.
// The datapath carries out one such step per cycle.
// One pair is worked on at a time. The receiver cannot stall; a result beat
// is always taken in its strobe cycle. Synchronous reset returns the
// controller to idle and clears busy and the strobe.
`default_nettype none

`include "assert_macros.svh"

module binary_gcd_unit #(
   parameter int WIDTH = bgcd_pkg::WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [bgcd_pkg::FIELD_WIDTH-1:0] req_first_value,
   input  wire logic [bgcd_pkg::FIELD_WIDTH-1:0] req_second_value,
   output logic                                  rsp_valid,
   output logic [bgcd_pkg::FIELD_WIDTH-1:0]      rsp_gcd_value
);

   bgcd_pkg::cmd_type    cmd;
   bgcd_pkg::status_type status;

   // Sequencer.
   bgcd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Operand registers and arithmetic.
   bgcd_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .rsp_valid        (rsp_valid),
      .rsp_gcd_value    (rsp_gcd_value)
   );

   // A result beat ends the job, so the unit is free in its strobe cycle.
   `ASSERT_NEVER(a_strobe_while_busy, clock, reset, rsp_valid && busy, "result while busy")

   // An accepted pair keeps the unit busy in the next cycle.
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept not busy")

   // Busy only rises on an accepted start.
   `ASSERT_CLK(a_busy_rise, clock, reset, $rose(busy) |-> $past(start), "busy without start")

   // No two result beats in a row: after a result the controller is idle and must load a new pair first.
   `ASSERT_CLK(a_single_strobe, clock, reset, rsp_valid |=> !rsp_valid, "double result")

endmodule

`default_nettype wire

>>> hw/rtl/bgcd_ctrl.sv
// Controller of the binary gcd unit: sequences load, strip, shift, subtract and emit steps.
// Depends on bgcd_pkg for the command and status structs.
`default_nettype none

module bgcd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire bgcd_pkg::status_type status,
   output bgcd_pkg::cmd_type        cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STRIP,
      ST_ITER
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state and the command for the current cycle.
   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd.op   = bgcd_pkg::OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = bgcd_pkg::OP_LOAD;
               state_in = ST_STRIP;
               busy_in  = 1'b1;
            end
         end
         ST_STRIP: begin
            // A zero smaller operand makes the larger one the answer.
            if (status.small_zero) begin
               cmd.op   = bgcd_pkg::OP_EMIT;
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end else if (status.big_even && status.small_even) begin
               cmd.op = bgcd_pkg::OP_SHIFT_BOTH;
            end else if (status.big_even) begin
               cmd.op = bgcd_pkg::OP_SHIFT_BIG;
            end else begin
               // The operand in the big register is odd now; start the reduction at once.
               state_in = ST_ITER;
               cmd.op   = status.small_even ? bgcd_pkg::OP_SHIFT_SMALL
                                            : bgcd_pkg::OP_SUBTRACT;
            end
         end
         ST_ITER: begin
            if (status.small_zero) begin
               cmd.op   = bgcd_pkg::OP_EMIT;
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end else if (status.small_even) begin
               cmd.op = bgcd_pkg::OP_SHIFT_SMALL;
            end else begin
               cmd.op = bgcd_pkg::OP_SUBTRACT;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bgcd_datapath.sv
// Datapath of the binary gcd unit: operand registers, shared-zero count,
// subtractors and the result register. Depends on bgcd_pkg.
`default_nettype none

module bgcd_datapath #(
   parameter int WIDTH = bgcd_pkg::WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bgcd_pkg::cmd_type                   cmd,
   output bgcd_pkg::status_type                     status,
   input  wire logic [bgcd_pkg::FIELD_WIDTH-1:0]    req_first_value,
   input  wire logic [bgcd_pkg::FIELD_WIDTH-1:0]    req_second_value,
   output logic                                     rsp_valid,
   output logic [bgcd_pkg::FIELD_WIDTH-1:0]         rsp_gcd_value
);

   localparam int FW    = bgcd_pkg::FIELD_WIDTH;
   localparam int EXT_W = (WIDTH > FW) ? WIDTH : FW;
   localparam int CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0] big_ff, big_in;
   logic [WIDTH-1:0] small_ff, small_in;
   logic [CNT_W-1:0] shift_ff, shift_in;
   logic             valid_ff, valid_in;
   logic [FW-1:0]    value_ff, value_in;

   logic [EXT_W-1:0] first_ext, second_ext, result_ext;
   logic [WIDTH-1:0] first_op, second_op;
   logic [WIDTH:0]   diff_bs;
   logic [WIDTH-1:0] diff_sb;

   // Operands are taken modulo 2^WIDTH.
   assign first_ext  = EXT_W'(req_first_value);
   assign second_ext = EXT_W'(req_second_value);
   assign first_op   = first_ext[WIDTH-1:0];
   assign second_op  = second_ext[WIDTH-1:0];

   // Both differences; the borrow of the first tells which operand is larger.
   assign diff_bs = {1'b0, big_ff} - {1'b0, small_ff};
   assign diff_sb = small_ff - big_ff;

   // Restore the shared power of two and fit the result to the port.
   assign result_ext = EXT_W'(big_ff << shift_ff);

   assign status.small_zero = (small_ff == '0);
   assign status.big_even   = ~big_ff[0];
   assign status.small_even = ~small_ff[0];

   always_comb begin
      big_in   = big_ff;
      small_in = small_ff;
      shift_in = shift_ff;
      valid_in = 1'b0;
      value_in = value_ff;
      case (cmd.op)
         bgcd_pkg::OP_LOAD: begin
            shift_in = '0;
            if (first_op >= second_op) begin
               big_in   = first_op;
               small_in = second_op;
            end else begin
               big_in   = second_op;
               small_in = first_op;
            end
         end
         bgcd_pkg::OP_SHIFT_BOTH: begin
            big_in   = big_ff >> 1;
            small_in = small_ff >> 1;
            shift_in = shift_ff + CNT_W'(1);
         end
         bgcd_pkg::OP_SHIFT_BIG: begin
            big_in = big_ff >> 1;
         end
         bgcd_pkg::OP_SHIFT_SMALL: begin
            small_in = small_ff >> 1;
         end
         bgcd_pkg::OP_SUBTRACT: begin
            // The smaller odd value stays, the difference is reduced further.
            if (!diff_bs[WIDTH]) begin
               big_in   = small_ff;
               small_in = diff_bs[WIDTH-1:0];
            end else begin
               small_in = diff_sb;
            end
         end
         bgcd_pkg::OP_EMIT: begin
            valid_in = 1'b1;
            value_in = result_ext[FW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      big_ff   <= big_in;
      small_ff <= small_in;
      shift_ff <= shift_in;
      value_ff <= value_in;
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_gcd_value = value_ff;

endmodule

`default_nettype wire
